[sv/crrm_pkg.sv]
// Shared constants, payload types and queue types for the chained range remapper.
package crrm_pkg;

    localparam int STAGES            = 7;
    localparam int WINDOWS_PER_STAGE = 32;
    localparam int STAGE_W           = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int SLOT_W            = (WINDOWS_PER_STAGE > 1) ? $clog2(WINDOWS_PER_STAGE) : 1;
    localparam int DATA_W            = 64;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    localparam logic [DATA_W-1:0] MIN_INIT = '1;

    typedef logic [STAGE_W-1:0] t_stage_idx;
    typedef logic [SLOT_W-1:0]  t_slot_idx;
    typedef logic [QPTR_W-1:0]  t_qptr;
    typedef logic [QPTR_W:0]    t_qcount;

    localparam t_stage_idx LAST_STAGE = t_stage_idx'(STAGES - 1);

    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        stage;
        logic [4:0]        slot;
        logic [DATA_W-1:0] dest_start;
        logic [DATA_W-1:0] src_start;
        logic [DATA_W-1:0] span_length;
        logic [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] location;
        logic [DATA_W-1:0] lowest_location;
    } t_out_item;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_WRITE = 2'd1,
        K_XLATE = 2'd2
    } t_kind;

    // A queued command; the window offset is dest_start - src_start.
    typedef struct packed {
        t_kind             kind;
        t_stage_idx        stage;
        t_slot_idx         slot;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] len;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] len;
    } t_window;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

[sv/crrm_front.sv]
// Front end: classifies accepted items and holds them in a short command queue.
module crrm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  crrm_pkg::t_in_item  i_item,
    input  logic                i_pop,
    output crrm_pkg::t_cmd      o_head,
    output crrm_pkg::t_q_status o_status
);

    crrm_pkg::t_cmd    r_queue [crrm_pkg::QUEUE_DEPTH];
    crrm_pkg::t_qptr   r_wr_ptr, n_wr_ptr;
    crrm_pkg::t_qptr   r_rd_ptr, n_rd_ptr;
    crrm_pkg::t_qcount r_count, n_count;

    crrm_pkg::t_cmd w_cmd;
    logic           w_keep;
    logic           w_push;
    logic           w_empty;
    logic           w_full;

    always_comb begin
        w_cmd.stage  = crrm_pkg::t_stage_idx'(i_item.stage);
        w_cmd.slot   = crrm_pkg::t_slot_idx'(i_item.slot);
        w_cmd.offset = i_item.dest_start - i_item.src_start;
        w_cmd.src    = i_item.src_start;
        w_cmd.len    = i_item.span_length;
        w_cmd.value  = i_item.value;
        w_cmd.kind   = crrm_pkg::K_CLEAR;
        w_keep       = 1'b0;
        unique case (i_item.operation)
            crrm_pkg::OP_CLEAR: begin
                w_cmd.kind = crrm_pkg::K_CLEAR;
                w_keep     = 1'b1;
            end
            crrm_pkg::OP_WRITE: begin
                // Writes aimed past the last stage or slot are dropped here.
                w_cmd.kind = crrm_pkg::K_WRITE;
                w_keep     = (int'(i_item.stage) < crrm_pkg::STAGES) &&
                             (int'(i_item.slot) < crrm_pkg::WINDOWS_PER_STAGE);
            end
            crrm_pkg::OP_XLATE: begin
                w_cmd.kind = crrm_pkg::K_XLATE;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == crrm_pkg::t_qcount'(crrm_pkg::QUEUE_DEPTH));
    assign w_push  = i_push && w_keep && !w_full;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop && !w_empty) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        priority if (w_push && !(i_pop && !w_empty)) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop && !w_empty) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head         = r_queue[r_rd_ptr];
    assign o_status.empty = w_empty;
    assign o_status.full  = w_full;

endmodule

[sv/crrm_back.sv]
// Back end: window memory, valid bits, stage-by-stage translation and running minimum.
module crrm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crrm_pkg::t_cmd      i_head,
    input  crrm_pkg::t_q_status i_status,
    output logic                o_pop,
    output crrm_pkg::t_out_item o_result,
    output logic                o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_MIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    crrm_pkg::t_window r_mem [crrm_pkg::STAGES][crrm_pkg::WINDOWS_PER_STAGE];
    crrm_pkg::t_window r_row [crrm_pkg::WINDOWS_PER_STAGE];

    logic [crrm_pkg::WINDOWS_PER_STAGE-1:0] r_valid [crrm_pkg::STAGES];
    logic [crrm_pkg::WINDOWS_PER_STAGE-1:0] n_valid [crrm_pkg::STAGES];

    logic [crrm_pkg::DATA_W-1:0] r_min, n_min;
    logic [crrm_pkg::DATA_W-1:0] r_v, n_v;
    logic [crrm_pkg::DATA_W-1:0] r_loc, n_loc;
    logic [crrm_pkg::DATA_W-1:0] r_low, n_low;
    crrm_pkg::t_stage_idx        r_stage, n_stage;
    logic                        r_strobe, n_strobe;

    logic                        w_pop;
    logic                        w_mem_we;
    crrm_pkg::t_stage_idx        w_rd_addr;
    logic [crrm_pkg::DATA_W-1:0] w_diff   [crrm_pkg::WINDOWS_PER_STAGE];
    logic [crrm_pkg::DATA_W-1:0] w_mapped [crrm_pkg::WINDOWS_PER_STAGE];
    logic [crrm_pkg::WINDOWS_PER_STAGE-1:0] w_hit;
    logic [crrm_pkg::DATA_W-1:0] w_stage_out;

    // All windows of the current stage are checked side by side.
    always_comb begin
        for (int w = 0; w < crrm_pkg::WINDOWS_PER_STAGE; w++) begin
            w_diff[w]   = r_v - r_row[w].src;
            w_mapped[w] = r_v + r_row[w].offset;
            w_hit[w]    = r_valid[r_stage][w] && (r_v >= r_row[w].src) &&
                          (w_diff[w] < r_row[w].len);
        end
    end

    // The lowest matching slot wins, so scan from the top down.
    always_comb begin
        w_stage_out = r_v;
        for (int w = crrm_pkg::WINDOWS_PER_STAGE - 1; w >= 0; w--) begin
            if (w_hit[w]) begin
                w_stage_out = w_mapped[w];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_min     = r_min;
        n_v       = r_v;
        n_loc     = r_loc;
        n_low     = r_low;
        n_stage   = r_stage;
        n_strobe  = 1'b0;
        w_pop     = 1'b0;
        w_mem_we  = 1'b0;
        w_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_status.empty) begin
                    w_pop = 1'b1;
                    unique case (i_head.kind)
                        crrm_pkg::K_CLEAR: begin
                            for (int s = 0; s < crrm_pkg::STAGES; s++) begin
                                n_valid[s] = '0;
                            end
                            n_min = crrm_pkg::MIN_INIT;
                        end
                        crrm_pkg::K_WRITE: begin
                            w_mem_we                        = 1'b1;
                            n_valid[i_head.stage][i_head.slot] = 1'b1;
                        end
                        crrm_pkg::K_XLATE: begin
                            n_v     = i_head.value;
                            n_stage = '0;
                            n_state = S_RUN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // Row for the next stage is fetched while this one is resolved.
                n_v = w_stage_out;
                if (r_stage == crrm_pkg::LAST_STAGE) begin
                    n_state = S_MIN;
                end else begin
                    n_stage   = r_stage + 1'b1;
                    w_rd_addr = r_stage + 1'b1;
                end
            end
            S_MIN: begin
                n_loc    = r_v;
                n_low    = (r_v < r_min) ? r_v : r_min;
                n_min    = n_low;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stage  <= '0;
            r_min    <= crrm_pkg::MIN_INIT;
            r_strobe <= 1'b0;
            for (int s = 0; s < crrm_pkg::STAGES; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_stage  <= n_stage;
            r_min    <= n_min;
            r_strobe <= n_strobe;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_loc <= n_loc;
        r_low <= n_low;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_head.stage][i_head.slot] <= '{offset: i_head.offset,
                                                  src:    i_head.src,
                                                  len:    i_head.len};
        end
        r_row <= r_mem[w_rd_addr];
    end

    assign o_pop                    = w_pop;
    assign o_strobe                 = r_strobe;
    assign o_result.location        = r_loc;
    assign o_result.lowest_location = r_low;

endmodule

[sv/chained_range_remap_min.sv]
// A translate item waits in the command queue, is popped by the idle back end, passes through the
// stages one stage row per cycle and then updates the minimum; the back end takes no new command
// until that translate is through, and clear and window write items are handled in its idle state.
// busy rises only when the four-entry command queue is full; results cannot be stalled.
// Reset (synchronous, active low) empties the queue, invalidates every window and sets the
// running minimum to all ones; window contents are not cleared.
module chained_range_remap_min (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  crrm_pkg::t_in_item  i_item,
    output crrm_pkg::t_out_item o_result,
    output logic                o_strobe
);

    crrm_pkg::t_cmd      w_head;
    crrm_pkg::t_q_status w_status;
    logic                w_pop;
    logic                w_accept;

    assign busy     = w_status.full;
    assign w_accept = start && !busy;

    crrm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_item   (i_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    crrm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("back end took an item from an empty queue");

    a_min_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.lowest_location <= o_result.location))
        else $error("running minimum exceeds the current location");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

endmodule

[bench/tb_chained_range_remap_min.sv]
// Self-checking testbench for chained_range_remap_min with a predicting scoreboard.
module tb_chained_range_remap_min;

    typedef logic [crrm_pkg::DATA_W-1:0] t_word;

    localparam int HALF_PERIOD   = 4;
    localparam int TOTAL_WINDOWS = crrm_pkg::STAGES * crrm_pkg::WINDOWS_PER_STAGE;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam t_word      ALL_ONES  = '1;

    // Tracks the window tables and the running minimum and holds the locations still owed.
    class remap_tracker;
        t_word               win_dest [TOTAL_WINDOWS];
        t_word               win_src  [TOTAL_WINDOWS];
        t_word               win_len  [TOTAL_WINDOWS];
        bit                  win_valid[TOTAL_WINDOWS];
        t_word               lowest;
        crrm_pkg::t_out_item pending_locations[$];
        int                  fail_count;

        function new();
            foreach (win_valid[k]) win_valid[k] = 1'b0;
            lowest     = crrm_pkg::MIN_INIT;
            fail_count = 0;
        endfunction

        function t_word through_stage(int st, t_word v);
            int k;
            for (int w = 0; w < crrm_pkg::WINDOWS_PER_STAGE; w++) begin
                k = st * crrm_pkg::WINDOWS_PER_STAGE + w;
                if (win_valid[k] && v >= win_src[k] && (v - win_src[k]) < win_len[k])
                    return win_dest[k] + (v - win_src[k]);
            end
            return v;
        endfunction

        function void note_item(crrm_pkg::t_in_item it);
            crrm_pkg::t_out_item owed;
            t_word               v;
            int                  k;
            case (it.operation)
                crrm_pkg::OP_CLEAR: begin
                    foreach (win_valid[i]) win_valid[i] = 1'b0;
                    lowest = crrm_pkg::MIN_INIT;
                end
                crrm_pkg::OP_WRITE: begin
                    if (int'(it.stage) < crrm_pkg::STAGES &&
                        int'(it.slot) < crrm_pkg::WINDOWS_PER_STAGE) begin
                        k = int'(it.stage) * crrm_pkg::WINDOWS_PER_STAGE + int'(it.slot);
                        win_dest[k]  = it.dest_start;
                        win_src[k]   = it.src_start;
                        win_len[k]   = it.span_length;
                        win_valid[k] = 1'b1;
                    end
                end
                crrm_pkg::OP_XLATE: begin
                    v = it.value;
                    for (int s = 0; s < crrm_pkg::STAGES; s++) v = through_stage(s, v);
                    if (v < lowest) lowest = v;
                    owed.location        = v;
                    owed.lowest_location = lowest;
                    pending_locations.push_back(owed);
                end
                default: ;
            endcase
        endfunction

        function void check_location(crrm_pkg::t_out_item got);
            crrm_pkg::t_out_item want;
            if (pending_locations.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual location %h lowest %h",
                         $time, got.location, got.lowest_location);
                fail_count++;
                return;
            end
            want = pending_locations.pop_front();
            if (got.location !== want.location) begin
                $display("%0t: location mismatch: expected %h, actual %h",
                         $time, want.location, got.location);
                fail_count++;
            end
            if (got.lowest_location !== want.lowest_location) begin
                $display("%0t: lowest_location mismatch: expected %h, actual %h",
                         $time, want.lowest_location, got.lowest_location);
                fail_count++;
            end
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    crrm_pkg::t_in_item  in_item = '0;
    crrm_pkg::t_out_item o_result;
    logic                o_strobe;

    remap_tracker tracker;
    bit           gaps_on;
    int           counted_items;
    int           stall_cycles = 0;

    chained_range_remap_min u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (in_item),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // A result at an edge always belongs to an earlier item, so it is checked first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) tracker.check_location(o_result);
            if (start && !busy) tracker.note_item(in_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** chained_range_remap_min: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_word rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic crrm_pkg::t_in_item noise_item(logic [1:0] op);
        crrm_pkg::t_in_item it;
        it.operation   = op;
        it.stage       = 3'($urandom);
        it.slot        = 5'($urandom);
        it.dest_start  = rand64();
        it.src_start   = rand64();
        it.span_length = rand64();
        it.value       = rand64();
        return it;
    endfunction

    // Start stays high from one item to the next when there is no gap between them.
    task automatic send_item(input crrm_pkg::t_in_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_locations.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_window(input int st, input int sl, input t_word dest,
                                input t_word src, input t_word len);
        crrm_pkg::t_in_item it;
        it             = noise_item(crrm_pkg::OP_WRITE);
        it.stage       = 3'(st);
        it.slot        = 5'(sl);
        it.dest_start  = dest;
        it.src_start   = src;
        it.span_length = len;
        send_item(it);
    endtask

    task automatic translate(input t_word v);
        crrm_pkg::t_in_item it;
        it       = noise_item(crrm_pkg::OP_XLATE);
        it.value = v;
        send_item(it);
    endtask

    task automatic clear_all();
        send_item(noise_item(crrm_pkg::OP_CLEAR));
    endtask

    // Narrow sessions keep every window in a small range so values chain through stages.
    task automatic run_session();
        bit                 narrow;
        int                 n_writes, n_xlates, j;
        t_word              ses_src[$], ses_len[$], ses_dest[$];
        t_word              src, len, dest, v;
        crrm_pkg::t_in_item it;
        narrow  = ($urandom_range(0, 1) == 0);
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) != 0) begin
            clear_all();
            counted_items++;
        end
        n_writes = $urandom_range(1, 40);
        n_xlates = $urandom_range(5, 40);
        for (int i = 0; i < n_writes + n_xlates; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(noise_item(OP_UNUSED));
                end else begin
                    it       = noise_item(crrm_pkg::OP_WRITE);
                    it.stage = 3'(crrm_pkg::STAGES);
                    send_item(it);
                end
            end
            if (i < n_writes || $urandom_range(0, 19) == 0) begin
                if (narrow) begin
                    src  = t_word'($urandom_range(0, 199));
                    len  = t_word'($urandom_range(0, 40));
                    dest = t_word'($urandom_range(0, 199));
                end else begin
                    dest = rand64();
                    if (ses_dest.size() != 0 && $urandom_range(0, 1) == 0)
                        src = ses_dest[$urandom_range(0, ses_dest.size() - 1)]
                              - $urandom_range(0, 3);
                    else
                        src = rand64();
                    len = ($urandom_range(0, 15) == 0) ? '0 : rand64() >> $urandom_range(0, 63);
                end
                ses_src.push_back(src);
                ses_len.push_back(len);
                ses_dest.push_back(dest);
                write_window($urandom_range(0, crrm_pkg::STAGES - 1), $urandom_range(0, 31),
                             dest, src, len);
            end else begin
                if (narrow) begin
                    v = t_word'($urandom_range(0, 239));
                end else if (ses_src.size() == 0 || $urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       v = '0;
                        1:       v = ALL_ONES;
                        default: v = rand64();
                    endcase
                end else begin
                    j   = $urandom_range(0, ses_src.size() - 1);
                    src = ses_src[j];
                    len = ses_len[j];
                    case ($urandom_range(0, 4))
                        0:       v = src;
                        1:       v = src + len - 1;
                        2:       v = src + len;
                        3:       v = src - 1;
                        default: v = (len == 0) ? src : src + (rand64() % len);
                    endcase
                end
                translate(v);
            end
            counted_items++;
        end
        if ($urandom_range(0, 2) == 0) wait_drained();
    endtask

    initial begin
        t_word              probe[12];
        crrm_pkg::t_in_item it;
        probe = '{64'd99, 64'd100, 64'd103, 64'd104, 64'd106, 64'd107, 64'd109, 64'd110,
                  ALL_ONES, ALL_ONES - 3, ALL_ONES - 4, 64'd0};
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on = 1'b0;
        translate(ALL_ONES);
        translate('0);
        clear_all();
        // Destination wraps past the top; a zero-length window never matches and a lower slot takes priority.
        write_window(0, 31, ALL_ONES - 4, 64'd100, 64'd10);
        write_window(0, 0, '0, 64'd105, '0);
        write_window(0, 1, 64'd1000, 64'd104, 64'd3);
        write_window(6, 5, '0, ALL_ONES - 3, ALL_ONES);
        write_window(3, 31, ALL_ONES, ALL_ONES, ALL_ONES);
        it             = noise_item(crrm_pkg::OP_WRITE);
        it.stage       = 3'(crrm_pkg::STAGES);
        it.src_start   = '0;
        it.span_length = ALL_ONES;
        send_item(it);
        send_item(noise_item(OP_UNUSED));
        gaps_on = 1'b1;
        foreach (probe[p]) translate(probe[p]);
        clear_all();
        translate(64'd5);
        wait_drained();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) run_session();

        start <= 1'b0;
        while (tracker.pending_locations.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0) begin
            $display("** chained_range_remap_min: PASSED **");
        end else begin
            $display("** chained_range_remap_min: FAILED **");
        end
        $finish;
    end

endmodule
